// ----- rtl/pid_controller_clamped_defines.svh -----
// Assertion macros shared by the PID controller RTL.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Check cond -> prop in the same cycle, off while in reset.
`define PCC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check cond -> prop in the following cycle, off while in reset.
`define PCC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/pcc_pkg.sv -----
// Types, codes, widths and saturation helpers for the PID controller.
// No dependencies; used by pcc_mdu and pid_controller_clamped.
package pcc_pkg;

  // Input command codes
  localparam logic [1:0] CMD_UPDATE   = 2'd0;
  localparam logic [1:0] CMD_SUPPLIED = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

  // Product terms, in the order they are accumulated
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // Iterative unit geometry
  localparam int STEPS   = 32;
  localparam int CNT_W   = $clog2(STEPS);
  localparam int AMAG_W  = 34;
  localparam int BMAG_W  = 32;
  localparam int PROD_W  = AMAG_W + BMAG_W;
  localparam int FRAC_W  = 16;
  localparam int MAG_W   = PROD_W - FRAC_W;
  localparam int ACC_W   = MAG_W + 3;

  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef enum logic [0:0] {
    OP_MUL,
    OP_DIV
  } pcc_op_t;

  typedef struct packed {
    logic    start;
    pcc_op_t op;
  } pcc_mdu_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } pcc_mdu_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INT_GO,
    ST_INT_RUN,
    ST_INT_ADD,
    ST_INT_CLAMP,
    ST_DER_SEL,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_DIV_POST,
    ST_TERM_GO,
    ST_TERM_RUN,
    ST_TERM_ACC,
    ST_SAT,
    ST_OUT
  } pcc_state_t;

  // Saturate a wide signed sum to 32 bits signed.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-32:0] upper;
    upper = v[ACC_W-1:31];
    if ((&upper) || (~|upper)) begin
      return v[31:0];
    end else if (v[ACC_W-1]) begin
      return INT32_MIN;
    end else begin
      return INT32_MAX;
    end
  endfunction

  // Clamp to +-lim.
  function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [32:0] vs;
    logic signed [32:0] ls;
    logic [31:0]        lim_pos;
    vs      = {v[31], v};
    ls      = {2'b00, lim};
    lim_pos = {1'b0, lim};
    priority if (vs > ls) begin
      return lim_pos;
    end else if (vs < -ls) begin
      return ~lim_pos + 32'd1;
    end else begin
      return v;
    end
  endfunction

  // Magnitude of a 34 bit signed value as 34 bits unsigned.
  function automatic logic [AMAG_W-1:0] mag34(input logic [AMAG_W-1:0] v);
    return v[AMAG_W-1] ? (~v + AMAG_W'(1)) : v;
  endfunction

endpackage

// ----- rtl/pcc_mdu.sv -----
// Shared iterative unit: shift-add multiply or restoring divide, one bit per cycle.
// Depends on pcc_pkg.
module pcc_mdu (
  input  logic                          clk,
  input  logic                          rst,
  input  pcc_pkg::pcc_mdu_ctl_t         ctl,
  input  logic [pcc_pkg::AMAG_W-1:0]    a_mag,
  input  logic [pcc_pkg::BMAG_W-1:0]    b_mag,
  input  logic [15:0]                   divisor,
  output pcc_pkg::pcc_mdu_stat_t        stat,
  output logic [pcc_pkg::PROD_W-1:0]    result
);

  logic                          running;
  logic [pcc_pkg::CNT_W-1:0]     cnt;
  logic                          done;
  logic                          ovf;
  pcc_pkg::pcc_op_t              op;
  logic [pcc_pkg::AMAG_W-1:0]    acc;
  logic [pcc_pkg::BMAG_W-1:0]    lo;
  logic [pcc_pkg::AMAG_W-1:0]    mcand;
  logic [15:0]                   dvsr;

  logic [pcc_pkg::AMAG_W:0]      opnd_a;
  logic [pcc_pkg::AMAG_W:0]      opnd_b;
  logic                          sub;
  logic [pcc_pkg::AMAG_W:0]      sum;

  // One adder serves both modes; divide subtracts.
  always_comb begin
    unique case (op)
      pcc_pkg::OP_DIV: begin
        opnd_a = {acc, lo[pcc_pkg::BMAG_W-1]};
        opnd_b = {{(pcc_pkg::AMAG_W-15){1'b0}}, dvsr};
        sub    = 1'b1;
      end
      pcc_pkg::OP_MUL: begin
        opnd_a = {1'b0, acc};
        opnd_b = lo[0] ? {1'b0, mcand} : '0;
        sub    = 1'b0;
      end
    endcase
    sum = opnd_a + (sub ? ~opnd_b : opnd_b) + {{pcc_pkg::AMAG_W{1'b0}}, sub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + pcc_pkg::CNT_W'(1);
        if (cnt == pcc_pkg::CNT_W'(pcc_pkg::STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op <= ctl.op;
      unique case (ctl.op)
        pcc_pkg::OP_DIV: begin
          acc  <= {16'd0, a_mag[pcc_pkg::AMAG_W-1:16]};
          lo   <= {a_mag[15:0], 16'd0};
          dvsr <= divisor;
          ovf  <= a_mag[pcc_pkg::AMAG_W-1:16] >= {2'b00, divisor};
        end
        pcc_pkg::OP_MUL: begin
          acc   <= '0;
          lo    <= b_mag;
          mcand <= a_mag;
          ovf   <= 1'b0;
        end
      endcase
    end else if (running) begin
      unique case (op)
        pcc_pkg::OP_DIV: begin
          // Keep the trial remainder only when it did not go negative.
          acc <= sum[pcc_pkg::AMAG_W] ? opnd_a[pcc_pkg::AMAG_W-1:0]
                                      : sum[pcc_pkg::AMAG_W-1:0];
          lo  <= {lo[pcc_pkg::BMAG_W-2:0], ~sum[pcc_pkg::AMAG_W]};
        end
        pcc_pkg::OP_MUL: begin
          acc <= sum[pcc_pkg::AMAG_W:1];
          lo  <= {sum[0], lo[pcc_pkg::BMAG_W-1:1]};
        end
      endcase
    end
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;
  assign result    = {acc, lo};

endmodule

// ----- rtl/pid_controller_clamped.sv -----
// Top level of the clamped PID controller: sequencer, state and output register.
// Depends on pcc_pkg, pcc_mdu and pid_controller_clamped_defines.svh.
//
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_stall   command setpoint measured time_step derivative_in
//  out      from block out_valid / out_stall drive
//  cfg      to block   cfg_valid / cfg_ready cfg_index cfg_data
//
// One item at a time. An update runs up to five passes of the 32-step shift-add /
// shift-subtract unit (error*time_step, the derivative divide, three gain products);
// a supplied derivative skips the divide, and a zero time step skips the integration
// pass and the divide. Clear and the unused command go straight to the output.
// Reset clears gains, limits, stored errors and integral. A stalled output holds the
// result; the next item is still taken and waits for the output slot at its end.
`include "pid_controller_clamped_defines.svh"
module pid_controller_clamped (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        command,
  input  logic signed [31:0]                setpoint,
  input  logic signed [31:0]                measured,
  input  logic [15:0]                       time_step,
  input  logic signed [31:0]                derivative_in,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                drive,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  pcc_pkg::pcc_state_t state;
  pcc_pkg::pcc_state_t state_next;

  // Configuration
  logic signed [31:0] kp_gain;
  logic signed [31:0] ki_gain;
  logic signed [31:0] kd_gain;
  logic [30:0]        integral_limit;
  logic [30:0]        output_limit;

  // Controller state
  logic signed [32:0] last_error;
  logic signed [32:0] prior_error;
  logic signed [31:0] integral_sum;

  // Per-item working registers
  logic [1:0]                       cmd_r;
  logic [15:0]                      dt_r;
  logic signed [31:0]               dsup_r;
  logic signed [31:0]               deriv;
  logic [pcc_pkg::AMAG_W-1:0]       diff;
  logic [pcc_pkg::ACC_W-1:0]        acc_sum;
  logic [1:0]                       term;
  logic                             term_neg_r;
  logic signed [31:0]               drive_pre;

  // Shared unit hookup
  pcc_pkg::pcc_mdu_ctl_t            mdu_ctl;
  pcc_pkg::pcc_mdu_stat_t           mdu_stat;
  logic [pcc_pkg::AMAG_W-1:0]       mdu_a;
  logic [pcc_pkg::BMAG_W-1:0]       mdu_b;
  logic [pcc_pkg::PROD_W-1:0]       mdu_res;

  logic [pcc_pkg::AMAG_W-1:0]       term_val;
  logic signed [31:0]               term_gain;
  logic                             term_neg;
  logic [pcc_pkg::AMAG_W-1:0]       gain_mag;
  logic [pcc_pkg::ACC_W-1:0]        m_ext;
  logic [pcc_pkg::ACC_W-1:0]        int_ext;
  logic [pcc_pkg::ACC_W-1:0]        int_sum;
  logic [31:0]                      quot;

  logic in_take;
  logic cfg_we;
  logic out_load;

  pcc_mdu u_mdu (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mdu_ctl),
    .a_mag   (mdu_a),
    .b_mag   (mdu_b),
    .divisor (dt_r),
    .stat    (mdu_stat),
    .result  (mdu_res)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      pcc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (command == pcc_pkg::CMD_UPDATE || command == pcc_pkg::CMD_SUPPLIED) begin
            state_next = pcc_pkg::ST_INT_GO;
          end else begin
            state_next = pcc_pkg::ST_OUT;
          end
        end
      end
      pcc_pkg::ST_INT_GO: begin
        // No integration with a zero time step; the clamp still applies.
        state_next = (dt_r == 16'd0) ? pcc_pkg::ST_INT_CLAMP : pcc_pkg::ST_INT_RUN;
      end
      pcc_pkg::ST_INT_RUN: begin
        if (mdu_stat.done) state_next = pcc_pkg::ST_INT_ADD;
      end
      pcc_pkg::ST_INT_ADD:   state_next = pcc_pkg::ST_INT_CLAMP;
      pcc_pkg::ST_INT_CLAMP: state_next = pcc_pkg::ST_DER_SEL;
      pcc_pkg::ST_DER_SEL: begin
        if (cmd_r == pcc_pkg::CMD_SUPPLIED || dt_r == 16'd0) begin
          state_next = pcc_pkg::ST_TERM_GO;
        end else begin
          state_next = pcc_pkg::ST_DIV_GO;
        end
      end
      pcc_pkg::ST_DIV_GO: state_next = pcc_pkg::ST_DIV_RUN;
      pcc_pkg::ST_DIV_RUN: begin
        if (mdu_stat.done) state_next = pcc_pkg::ST_DIV_POST;
      end
      pcc_pkg::ST_DIV_POST: state_next = pcc_pkg::ST_TERM_GO;
      pcc_pkg::ST_TERM_GO:  state_next = pcc_pkg::ST_TERM_RUN;
      pcc_pkg::ST_TERM_RUN: begin
        if (mdu_stat.done) state_next = pcc_pkg::ST_TERM_ACC;
      end
      pcc_pkg::ST_TERM_ACC: begin
        state_next = (term == pcc_pkg::TERM_D) ? pcc_pkg::ST_SAT : pcc_pkg::ST_TERM_GO;
      end
      pcc_pkg::ST_SAT: state_next = pcc_pkg::ST_OUT;
      pcc_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) state_next = pcc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall      = (state != pcc_pkg::ST_IDLE);
    // Take register writes only with nothing in flight or waiting at the output.
    cfg_ready     = (state == pcc_pkg::ST_IDLE) && !out_valid;
    out_load      = (state == pcc_pkg::ST_OUT) && (!out_valid || !out_stall);
    mdu_ctl.start = 1'b0;
    mdu_ctl.op    = pcc_pkg::OP_MUL;
    unique case (state)
      pcc_pkg::ST_INT_GO: begin
        mdu_ctl.start = (dt_r != 16'd0);
      end
      pcc_pkg::ST_DIV_GO: begin
        mdu_ctl.start = 1'b1;
        mdu_ctl.op    = pcc_pkg::OP_DIV;
      end
      pcc_pkg::ST_TERM_GO: begin
        mdu_ctl.start = 1'b1;
      end
      pcc_pkg::ST_IDLE, pcc_pkg::ST_INT_RUN, pcc_pkg::ST_INT_ADD, pcc_pkg::ST_INT_CLAMP,
      pcc_pkg::ST_DER_SEL, pcc_pkg::ST_DIV_RUN, pcc_pkg::ST_DIV_POST, pcc_pkg::ST_TERM_RUN,
      pcc_pkg::ST_TERM_ACC, pcc_pkg::ST_SAT, pcc_pkg::ST_OUT: begin
        mdu_ctl.start = 1'b0;
      end
    endcase
  end

  assign in_take = in_valid && !in_stall;
  assign cfg_we  = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------------------
  // Operand selection for the shared unit
  // ---------------------------------------------------------------------------
  always_comb begin
    case (term)
      pcc_pkg::TERM_P: begin
        term_val  = {last_error[32], last_error};
        term_gain = kp_gain;
      end
      pcc_pkg::TERM_I: begin
        term_val  = {{2{integral_sum[31]}}, integral_sum};
        term_gain = ki_gain;
      end
      pcc_pkg::TERM_D: begin
        term_val  = {{2{deriv[31]}}, deriv};
        term_gain = kd_gain;
      end
      default: begin
        term_val  = '0;
        term_gain = '0;
      end
    endcase
    // Sign-magnitude products: truncate the magnitude, then apply the sign.
    term_neg = term_val[pcc_pkg::AMAG_W-1] ^ term_gain[31];
    gain_mag = pcc_pkg::mag34({{2{term_gain[31]}}, term_gain});

    if (state == pcc_pkg::ST_INT_GO) begin
      mdu_a = pcc_pkg::mag34({last_error[32], last_error});
      mdu_b = {16'd0, dt_r};
    end else if (state == pcc_pkg::ST_DIV_GO) begin
      mdu_a = pcc_pkg::mag34(diff);
      mdu_b = '0;
    end else begin
      mdu_a = pcc_pkg::mag34(term_val);
      mdu_b = gain_mag[pcc_pkg::BMAG_W-1:0];
    end
  end

  // Truncated product magnitude and the integral update sum.
  assign m_ext   = {{(pcc_pkg::ACC_W-pcc_pkg::MAG_W){1'b0}},
                    mdu_res[pcc_pkg::PROD_W-1:pcc_pkg::FRAC_W]};
  assign int_ext = {{(pcc_pkg::ACC_W-32){integral_sum[31]}}, integral_sum};
  assign int_sum = last_error[32] ? (int_ext - m_ext) : (int_ext + m_ext);
  assign quot    = mdu_res[31:0];

  // ---------------------------------------------------------------------------
  // Sequencer state, configuration and controller state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pcc_pkg::ST_IDLE;
      term           <= pcc_pkg::TERM_P;
      kp_gain        <= '0;
      ki_gain        <= '0;
      kd_gain        <= '0;
      integral_limit <= '0;
      output_limit   <= '0;
      last_error     <= '0;
      prior_error    <= '0;
      integral_sum   <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          pcc_pkg::REG_KP_GAIN: kp_gain <= cfg_data;
          pcc_pkg::REG_KI_GAIN: begin
            // Drop the integral when the integral gain is switched off.
            if (cfg_data == 32'd0 && ki_gain != 32'sd0) integral_sum <= '0;
            ki_gain <= cfg_data;
          end
          pcc_pkg::REG_KD_GAIN:        kd_gain        <= cfg_data;
          pcc_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[30:0];
          pcc_pkg::REG_OUTPUT_LIMIT:   output_limit   <= cfg_data[30:0];
          default: ;
        endcase
      end

      unique case (state)
        pcc_pkg::ST_IDLE: begin
          if (in_take) begin
            if (command == pcc_pkg::CMD_UPDATE || command == pcc_pkg::CMD_SUPPLIED) begin
              prior_error <= last_error;
              last_error  <= {setpoint[31], setpoint} - {measured[31], measured};
            end else if (command == pcc_pkg::CMD_CLEAR) begin
              last_error   <= '0;
              prior_error  <= '0;
              integral_sum <= '0;
            end
          end
        end
        pcc_pkg::ST_INT_ADD:   integral_sum <= pcc_pkg::sat32(int_sum);
        pcc_pkg::ST_INT_CLAMP: integral_sum <= pcc_pkg::clamp_mag(integral_sum,
                                                                  integral_limit);
        pcc_pkg::ST_DER_SEL:   term <= pcc_pkg::TERM_P;
        pcc_pkg::ST_TERM_ACC:  term <= term + 2'd1;
        pcc_pkg::ST_INT_GO, pcc_pkg::ST_INT_RUN, pcc_pkg::ST_DIV_GO, pcc_pkg::ST_DIV_RUN,
        pcc_pkg::ST_DIV_POST, pcc_pkg::ST_TERM_GO, pcc_pkg::ST_TERM_RUN, pcc_pkg::ST_SAT,
        pcc_pkg::ST_OUT: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-item working registers (no reset, always written before use)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      pcc_pkg::ST_IDLE: begin
        if (in_take) begin
          cmd_r     <= command;
          dt_r      <= time_step;
          dsup_r    <= derivative_in;
          drive_pre <= '0;
        end
      end
      pcc_pkg::ST_DER_SEL: begin
        acc_sum <= '0;
        if (cmd_r == pcc_pkg::CMD_SUPPLIED) begin
          deriv <= dsup_r;
        end else if (dt_r == 16'd0) begin
          deriv <= '0;
        end else begin
          diff <= {last_error[32], last_error} - {prior_error[32], prior_error};
        end
      end
      pcc_pkg::ST_DIV_POST: begin
        // Quotient at or above 2^31 saturates toward the sign of the difference.
        if (mdu_stat.ovf || quot[31]) begin
          deriv <= diff[pcc_pkg::AMAG_W-1] ? pcc_pkg::INT32_MIN : pcc_pkg::INT32_MAX;
        end else begin
          deriv <= diff[pcc_pkg::AMAG_W-1] ? (~quot + 32'd1) : quot;
        end
      end
      pcc_pkg::ST_TERM_GO:  term_neg_r <= term_neg;
      pcc_pkg::ST_TERM_ACC: acc_sum <= term_neg_r ? (acc_sum - m_ext) : (acc_sum + m_ext);
      pcc_pkg::ST_SAT:      drive_pre <= pcc_pkg::sat32(acc_sum);
      pcc_pkg::ST_INT_GO, pcc_pkg::ST_INT_RUN, pcc_pkg::ST_INT_ADD, pcc_pkg::ST_INT_CLAMP,
      pcc_pkg::ST_DIV_GO, pcc_pkg::ST_DIV_RUN, pcc_pkg::ST_TERM_RUN, pcc_pkg::ST_OUT: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the result until taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive <= pcc_pkg::clamp_mag(drive_pre, output_limit);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PCC_ASSERT_NOW(a_integral_bound, state == pcc_pkg::ST_DER_SEL, ($signed({integral_sum[31], integral_sum}) <= $signed({2'b00, integral_limit})) && ($signed({integral_sum[31], integral_sum}) >= -$signed({2'b00, integral_limit})), "integral outside its limit after clamp")
  `PCC_ASSERT_NOW(a_drive_bound, out_valid, ($signed({drive[31], drive}) <= $signed({2'b00, output_limit})) && ($signed({drive[31], drive}) >= -$signed({2'b00, output_limit})), "drive outside output limit")
  `PCC_ASSERT_NOW(a_mdu_done_run, mdu_stat.done, (state == pcc_pkg::ST_INT_RUN) || (state == pcc_pkg::ST_DIV_RUN) || (state == pcc_pkg::ST_TERM_RUN), "shared unit finished outside a run state")
  `PCC_ASSERT_NEXT(a_out_load, out_load, out_valid && (state == pcc_pkg::ST_IDLE), "result load did not present an item")

endmodule

// ----- verif/tb_pid_controller_clamped.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pid_controller_clamped: a directed table, then random items
// in four idling phases; each drive checked against a typed-in value or a cycle-free model.
// Depends on pcc_pkg and the pid_controller_clamped RTL.
module tb_pid_controller_clamped;

  localparam int CLK_HALF           = 5;
  localparam int RESET_CYCLES       = 10;
  // The watchdog limit covers the slowest item and the long output hold-off.
  localparam int WATCHDOG_LIMIT     = 20000;
  localparam int DRAIN_CYCLES       = 250;
  localparam int HOLD_CYCLES        = 2000;
  localparam int HOLD_AFTER_ITEMS   = 60;
  localparam int PHASES             = 4;
  localparam int GAIN_SETS_PER_PHASE = 3;
  localparam int ITEMS_PER_GAIN_SET = 92;
  localparam int MAX_REPORTS        = 10;

  // Command code the block leaves unused, and a register index with no register.
  localparam logic [1:0]                    CMD_UNUSED = 2'd3;
  localparam logic [pcc_pkg::CFG_IDX_W-1:0] REG_NONE   = 3'd7;

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam longint      WORD_MAX = longint'(pcc_pkg::INT32_MAX);
  localparam longint      WORD_MIN = longint'(pcc_pkg::INT32_MIN);

  typedef enum logic {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_t;

  // One line of the directed table: a register write or an input item, with an
  // optional drive value typed in by hand.
  typedef struct packed {
    row_kind_t                     kind;
    logic [pcc_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [31:0]                   reg_data;
    logic [1:0]                    cmd;
    logic [31:0]                   sp;
    logic [31:0]                   meas;
    logic [15:0]                   dt;
    logic [31:0]                   dsup;
    logic                          known;
    logic [31:0]                   known_drive;
  } row_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] drive;
  } drive_exp_t;

  // DUT ports; the driven ones are known from time zero
  logic                          clk           = 1'b0;
  logic                          rst           = 1'b1;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic [1:0]                    command       = '0;
  logic signed [31:0]            setpoint      = '0;
  logic signed [31:0]            measured      = '0;
  logic [15:0]                   time_step     = '0;
  logic signed [31:0]            derivative_in = '0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic signed [31:0]            drive;
  logic                          cfg_valid     = 1'b0;
  logic                          cfg_ready;
  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [31:0]                   cfg_data      = '0;

  // Controller model: registers and state, reset values
  longint kp_q = 0, ki_q = 0, kd_q = 0, int_lim = 0, out_lim = 0;
  longint err_now = 0, err_prev = 0, integ = 0;

  drive_exp_t pending_drive[$];
  drive_exp_t head_exp;
  row_t       plan[$];
  int         item_count = 0;
  int         mismatches = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         items_seen = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  pid_controller_clamped i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .setpoint      (setpoint),
    .measured      (measured),
    .time_step     (time_step),
    .derivative_in (derivative_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller model
  // ---------------------------------------------------------------------------
  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [63:0] abs_val(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Exact product of two Q16.16 values (or Q16.16 by Q0.16), truncated toward zero.
  function automatic longint mul_q16(input longint a, input longint b);
    logic [63:0] m;
    m = (abs_val(a) * abs_val(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Advance the controller by one item and return its drive.
  function automatic logic [31:0] step_controller(input logic [1:0] cmd,
                                                  input logic [31:0] sp,
                                                  input logic [31:0] meas,
                                                  input logic [15:0] dt,
                                                  input logic [31:0] dsup);
    longint      slope;
    longint      total;
    longint      diff;
    logic [63:0] quot;
    if (cmd == pcc_pkg::CMD_CLEAR) begin
      err_now  = 0;
      err_prev = 0;
      integ    = 0;
      return '0;
    end
    if (cmd == CMD_UNUSED) return '0;
    err_prev = err_now;
    err_now  = longint'($signed(sp)) - longint'($signed(meas));
    if (dt != 0) integ = sat_word(integ + mul_q16(err_now, longint'(dt)));
    // The integral clamp applies on every update, with or without a time step.
    integ = clamp_sym(integ, int_lim);
    if (cmd == pcc_pkg::CMD_SUPPLIED) begin
      slope = longint'($signed(dsup));
    end else if (dt == 0) begin
      slope = 0;
    end else begin
      diff = err_now - err_prev;
      quot = (abs_val(diff) << 16) / 64'(dt);
      if (quot > 64'h8000_0000) quot = 64'h8000_0000;
      slope = sat_word((diff < 0) ? -longint'(quot) : longint'(quot));
    end
    total = mul_q16(err_now, kp_q) + mul_q16(integ, ki_q) + mul_q16(slope, kd_q);
    return 32'(clamp_sym(sat_word(total), out_lim));
  endfunction

  function automatic void apply_reg(input logic [pcc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
    case (idx)
      pcc_pkg::REG_KP_GAIN: kp_q = longint'($signed(data));
      pcc_pkg::REG_KI_GAIN: begin
        // Turning the integral gain off drops the accumulated integral.
        if (data == '0 && ki_q != 0) integ = 0;
        ki_q = longint'($signed(data));
      end
      pcc_pkg::REG_KD_GAIN:        kd_q    = longint'($signed(data));
      pcc_pkg::REG_INTEGRAL_LIMIT: int_lim = longint'({1'b0, data[30:0]});
      pcc_pkg::REG_OUTPUT_LIMIT:   out_lim = longint'({1'b0, data[30:0]});
      default: ;
    endcase
  endfunction

  function automatic void flag_bad(input string what, input logic [31:0] tag,
                                   input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s, item %0d: expected %h, got %h", $time, what, tag, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic row_t item_row(input logic [1:0] cmd, input logic [31:0] sp,
                                    input logic [31:0] meas, input logic [15:0] dt,
                                    input logic [31:0] dsup, input logic known,
                                    input logic [31:0] want);
    row_t r;
    r             = '0;
    r.kind        = ROW_ITEM;
    r.cmd         = cmd;
    r.sp          = sp;
    r.meas        = meas;
    r.dt          = dt;
    r.dsup        = dsup;
    r.known       = known;
    r.known_drive = want;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [pcc_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [31:0] data);
    row_t r;
    r          = '0;
    r.kind     = ROW_WRITE;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random picks
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return $urandom_range(1) ? POS_MAX : NEG_MAX;
      2:       return $urandom_range(32'h0008_0000) - 32'h0004_0000;  // within +-4.0
      default: return $urandom();
    endcase
  endfunction

  // Bit 31 of a limit write is random: the register holds only 31 bits.
  function automatic logic [31:0] pick_limit();
    case ($urandom_range(4))
      0:       return {1'($urandom_range(1)), 31'h0};
      1:       return {1'($urandom_range(1)), 31'h7fff_ffff};
      2:       return {1'($urandom_range(1)), 31'($urandom_range(32'h0010_0000))};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return $urandom_range(1) ? POS_MAX : NEG_MAX;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;  // within +-16.0
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'($urandom_range(16, 1));
      2:       return 16'hffff;
      3:       return 16'($urandom_range(16'hffff));
      default: return 16'($urandom_range(16'h2000, 16'h0100));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [pcc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait until every expected drive has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  // Offer one item, hold it until taken, then record its expected drive.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] sp,
                           input logic [31:0] meas, input logic [15:0] dt,
                           input logic [31:0] dsup, input logic known,
                           input logic [31:0] want);
    int          gap;
    logic [31:0] predicted;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      // Mostly short gaps; now and then one long enough to land on any phase of the work.
      gap = ($urandom_range(3) == 0) ? $urandom_range(220, 1) : $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    setpoint      <= sp;
    measured      <= meas;
    time_step     <= dt;
    derivative_in <= dsup;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = step_controller(cmd, sp, meas, dt, dsup);
    pending_drive.push_back('{tag: item_count, drive: known ? want : predicted});
    item_count++;
  endtask

  task automatic random_item();
    int         pick;
    logic [1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 45)      cmd = pcc_pkg::CMD_UPDATE;
    else if (pick < 88) cmd = pcc_pkg::CMD_SUPPLIED;
    else if (pick < 95) cmd = pcc_pkg::CMD_CLEAR;
    else                cmd = CMD_UNUSED;
    send_item(cmd, pick_value(), pick_value(), pick_step(), pick_value(), 1'b0, '0);
  endtask

  // First set is all extremes; the rest are random, now and then poking a missing register.
  task automatic load_gains(input int set_no);
    if (set_no == 0) begin
      write_reg(pcc_pkg::REG_KP_GAIN, NEG_MAX);
      write_reg(pcc_pkg::REG_KI_GAIN, POS_MAX);
      write_reg(pcc_pkg::REG_KD_GAIN, NEG_MAX);
      write_reg(pcc_pkg::REG_INTEGRAL_LIMIT, 32'hffff_ffff);
      write_reg(pcc_pkg::REG_OUTPUT_LIMIT, 32'hffff_ffff);
    end else begin
      write_reg(pcc_pkg::REG_KP_GAIN, pick_gain());
      write_reg(pcc_pkg::REG_KI_GAIN, pick_gain());
      write_reg(pcc_pkg::REG_KD_GAIN, pick_gain());
      write_reg(pcc_pkg::REG_INTEGRAL_LIMIT, pick_limit());
      write_reg(pcc_pkg::REG_OUTPUT_LIMIT, pick_limit());
      if ($urandom_range(3) == 0) write_reg(REG_NONE, $urandom());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each taken drive, pick the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) items_seen++;
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_drive.size() == 0) begin
          flag_bad("drive with nothing pending", item_count, 'x, drive);
        end else begin
          head_exp = pending_drive.pop_front();
          if (drive !== head_exp.drive)
            flag_bad("drive mismatch", head_exp.tag, head_exp.drive, drive);
        end
      end
      // Once, hold the output off long enough that the block fills and stalls its input.
      if (!hold_done && items_seen >= HOLD_AFTER_ITEMS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on any channel for too long
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int s;
    int n;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight out of reset every gain and limit is zero: all drives are zero.
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, POS_MAX, NEG_MAX, 16'hffff, '0, 1'b1, '0));
    plan.push_back(item_row(pcc_pkg::CMD_SUPPLIED, NEG_MAX, POS_MAX, '0, POS_MAX, 1'b1, '0));
    // Unused command: state untouched, drive zero.
    plan.push_back(item_row(CMD_UNUSED, '1, '1, '1, '1, 1'b1, '0));
    plan.push_back(item_row(pcc_pkg::CMD_CLEAR, POS_MAX, NEG_MAX, '1, '1, 1'b1, '0));
    // Proportional only, unit gain, wide limits.
    plan.push_back(reg_row(pcc_pkg::REG_KP_GAIN, Q_ONE));
    plan.push_back(reg_row(pcc_pkg::REG_OUTPUT_LIMIT, POS_MAX));
    plan.push_back(reg_row(pcc_pkg::REG_INTEGRAL_LIMIT, POS_MAX));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, Q_ONE, '0, '0, '0, 1'b1, Q_ONE));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, POS_MAX, NEG_MAX, '0, '0, 1'b1, POS_MAX));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, NEG_MAX, POS_MAX, '0, '0, 1'b1,
                            32'h8000_0001));
    // Tight output clamp on both sides.
    plan.push_back(reg_row(pcc_pkg::REG_OUTPUT_LIMIT, 32'h0000_0100));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, Q_ONE, '0, '0, '0, 1'b1, 32'h0000_0100));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, '0, Q_ONE, '0, '0, 1'b1, 32'hffff_ff00));
    // Integral only, clamped to +-2.0; bit 31 of the limit write is ignored.
    plan.push_back(reg_row(pcc_pkg::REG_OUTPUT_LIMIT, 32'hffff_ffff));
    plan.push_back(reg_row(pcc_pkg::REG_KP_GAIN, '0));
    plan.push_back(reg_row(pcc_pkg::REG_KI_GAIN, Q_ONE));
    plan.push_back(reg_row(pcc_pkg::REG_INTEGRAL_LIMIT, 32'h0002_0000));
    plan.push_back(item_row(pcc_pkg::CMD_CLEAR, '0, '0, '0, '0, 1'b1, '0));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, Q_ONE, '0, 16'h8000, '0, 1'b0, '0));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, POS_MAX, '0, 16'hffff, '0, 1'b1,
                            32'h0002_0000));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, NEG_MAX, POS_MAX, 16'hffff, '0, 1'b1,
                            32'hfffe_0000));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, '0, '0, '0, '0, 1'b0, '0));
    // Switching the integral gain off and on again leaves an empty integral.
    plan.push_back(reg_row(pcc_pkg::REG_KI_GAIN, '0));
    plan.push_back(reg_row(pcc_pkg::REG_KI_GAIN, Q_ONE));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, '0, '0, '0, '0, 1'b1, '0));
    // A zero integral limit pins the integral at zero.
    plan.push_back(reg_row(pcc_pkg::REG_INTEGRAL_LIMIT, '0));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, Q_ONE, '0, 16'hffff, '0, 1'b1, '0));
    // Derivative only: supplied extremes, zero time step, saturating divide.
    plan.push_back(reg_row(pcc_pkg::REG_KI_GAIN, '0));
    plan.push_back(reg_row(pcc_pkg::REG_KD_GAIN, Q_ONE));
    plan.push_back(reg_row(pcc_pkg::REG_INTEGRAL_LIMIT, POS_MAX));
    plan.push_back(item_row(pcc_pkg::CMD_SUPPLIED, '0, '0, 16'hffff, POS_MAX, 1'b1,
                            POS_MAX));
    plan.push_back(item_row(pcc_pkg::CMD_SUPPLIED, '0, '0, '0, NEG_MAX, 1'b1,
                            32'h8000_0001));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, Q_ONE, '0, '0, '0, 1'b1, '0));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, POS_MAX, NEG_MAX, 16'h0001, '0, 1'b0, '0));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, Q_ONE, 32'h0000_8000, 16'h4000, '0, 1'b0,
                            '0));
    // Extreme gains, plus a write to an index with no register behind it.
    plan.push_back(reg_row(pcc_pkg::REG_KP_GAIN, NEG_MAX));
    plan.push_back(reg_row(pcc_pkg::REG_KI_GAIN, NEG_MAX));
    plan.push_back(reg_row(pcc_pkg::REG_KD_GAIN, POS_MAX));
    plan.push_back(reg_row(REG_NONE, 32'hffff_ffff));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, NEG_MAX, POS_MAX, 16'hffff, '0, 1'b0, '0));
    plan.push_back(item_row(pcc_pkg::CMD_SUPPLIED, POS_MAX, NEG_MAX, 16'hffff, NEG_MAX,
                            1'b0, '0));
    plan.push_back(item_row(pcc_pkg::CMD_CLEAR, '1, '1, '1, '1, 1'b1, '0));
    plan.push_back(item_row(pcc_pkg::CMD_UPDATE, 32'h0000_0005, 32'hffff_fffb, 16'h0010,
                            '0, 1'b0, '0));

    // Walk the table; drain before every register write.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_item(plan[i].cmd, plan[i].sp, plan[i].meas, plan[i].dt, plan[i].dsup,
                  plan[i].known, plan[i].known_drive);
      end
    end

    // Random part: one idling pattern per phase, fresh gains every few dozen items.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (s = 0; s < GAIN_SETS_PER_PHASE; s++) begin
        settle();
        load_gains(p * GAIN_SETS_PER_PHASE + s);
        for (n = 0; n < ITEMS_PER_GAIN_SET; n++) random_item();
      end
    end

    settle();
    // Give any stray drive time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_drive.size() != 0)
      flag_bad("drive never arrived", pending_drive[0].tag, pending_drive[0].drive, 'x);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pcc_mdu.sv
rtl/pid_controller_clamped.sv
verif/tb_pid_controller_clamped.sv
